@@ sv/fpi_pkg.sv @@
// Shared types, constants and record arithmetic for the FASTA pack and index block.
`default_nettype none

package fpi_pkg;

    localparam int INDEX_BITS = 32;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

    localparam logic [7:0] CHAR_GT = 8'h3E;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_NL = 8'h0A;

    localparam logic CFG_DELIMITER = 1'b0;
    localparam logic CFG_BASE_ID = 1'b1;

    typedef logic [INDEX_BITS-1:0] idx_t;

    typedef enum logic [2:0] {
        MODE_START  = 3'b001,
        MODE_HEADER = 3'b010,
        MODE_SEQ    = 3'b100
    } line_mode_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic [31:0] write_index;
        logic        record_valid;
        logic [31:0] record_id;
        logic [31:0] record_start;
        logic [31:0] name_length;
        logic [31:0] residue_length;
        logic [31:0] longest_residue;
        logic [31:0] total_residue;
        logic        format_error;
        logic        run_last;
    } result_t;

    typedef struct packed {
        logic [1:0]        count;
        result_t [1:0]     item;
    } push_t;

    function automatic result_t byte_item(logic [7:0] b, idx_t pos);
        result_t r;
        r = '0;
        r.byte_valid = 1'b1;
        r.out_byte = b;
        r.write_index = 32'(pos);
        return r;
    endfunction

    // Delimiter byte plus the record for the sequence that it closes.
    function automatic result_t record_item(idx_t pos, idx_t hash_pos, idx_t hstart,
                                            logic [31:0] id, logic [7:0] delim,
                                            logic [31:0] max_len, logic [31:0] sum_len);
        result_t     r;
        idx_t        res_i;
        logic [31:0] res32;
        logic [32:0] sum33;
        r = byte_item(delim, pos);
        res_i = idx_t'(pos - hash_pos);
        if (delim == 8'h00)
        begin
            res_i = idx_t'(res_i - idx_t'(1));
        end
        res32 = 32'(res_i);
        sum33 = {1'b0, sum_len} + {1'b0, res32};
        r.record_valid = 1'b1;
        r.record_id = id;
        r.record_start = 32'(hstart);
        r.name_length = 32'(idx_t'(hash_pos - hstart));
        r.residue_length = res32;
        r.longest_residue = (res32 > max_len) ? res32 : max_len;
        r.total_residue = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/fasta_pack_and_index_top.sv @@
// Top level of the FASTA pack and index block: input register, parser, result queue.
//
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_byte, end_of_buffer
// out       out_valid / out_ready  byte_valid .. run_last (one result per item)
// cfg       cfg_we                 cfg_index, cfg_data
//
// One input byte a cycle while the queue has room; each byte yields zero, one or two
// results, and one result leaves per cycle while out_ready is high.
// A byte passes the input register and then enters the four-entry result queue.
// in_ready depends only on registered state: the input register is free or the
// queue holds at most two results. Reset clears all control and parser state.
`default_nettype none

module fasta_pack_and_index_top
    import fpi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_buffer,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             byte_valid,
    output logic [7:0]       out_byte,
    output logic [31:0]      write_index,
    output logic             record_valid,
    output logic [31:0]      record_id,
    output logic [31:0]      record_start,
    output logic [31:0]      name_length,
    output logic [31:0]      residue_length,
    output logic [31:0]      longest_residue,
    output logic [31:0]      total_residue,
    output logic             format_error,
    output logic             run_last,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [7:0]  delim_reg;
    logic [31:0] base_id_reg;
    logic        in_vld_reg;
    logic [7:0]  byte_reg;
    logic        eob_reg;
    logic        room;
    logic        go;
    push_t       push;
    result_t     head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= '0;
            base_id_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DELIMITER: delim_reg <= cfg_data[7:0];
                CFG_BASE_ID:   base_id_reg <= cfg_data;
                default:       delim_reg <= delim_reg;
            endcase
        end
    end

    assign go = in_vld_reg && room;
    assign in_ready = !in_vld_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            eob_reg <= end_of_buffer;
        end
    end

    fpi_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .b        (byte_reg),
        .eob      (eob_reg),
        .delim    (delim_reg),
        .base_id  (base_id_reg),
        .push     (push)
    );

    fpi_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign byte_valid = head.byte_valid;
    assign out_byte = head.out_byte;
    assign write_index = head.write_index;
    assign record_valid = head.record_valid;
    assign record_id = head.record_id;
    assign record_start = head.record_start;
    assign name_length = head.name_length;
    assign residue_length = head.residue_length;
    assign longest_residue = head.longest_residue;
    assign total_residue = head.total_residue;
    assign format_error = head.format_error;
    assign run_last = head.run_last;

    a_record_has_delim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_valid |-> byte_valid)
        else $error("record without its delimiter byte");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && format_error |-> !byte_valid && !record_valid && run_last)
        else $error("format error result carries data");

    a_running_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_valid |-> longest_residue >= residue_length
            && total_residue >= residue_length)
        else $error("running max or sum below record length");

    a_push_needs_go: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> go)
        else $error("results pushed without a byte in work");

endmodule

`default_nettype wire

@@ sv/fpi_step.sv @@
// Per-byte parser: line state, positions and record bookkeeping; emits up to two results.
`default_nettype none

module fpi_step
    import fpi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [7:0]  b,
    input  wire logic        eob,
    input  wire logic [7:0]  delim,
    input  wire logic [31:0] base_id,
    output push_t            push
);

    line_mode_t  mode_reg, mode_next;
    logic        pend_reg, pend_next;
    logic        first_reg, first_next;
    logic        err_reg, err_next;
    idx_t        pos_reg, pos_next;
    idx_t        hstart_reg, hstart_next;
    idx_t        hash_reg, hash_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] max_reg, max_next;
    logic [31:0] sum_reg, sum_next;

    result_t     res_v [2];
    logic [1:0]  n;
    logic        do_hdr;
    logic        hdr_hash;
    logic        do_seq;

    always_comb
    begin
        mode_next = mode_reg;
        pend_next = pend_reg;
        first_next = first_reg;
        err_next = err_reg;
        pos_next = pos_reg;
        hstart_next = hstart_reg;
        hash_next = hash_reg;
        id_next = id_reg;
        max_next = max_reg;
        sum_next = sum_reg;
        res_v[0] = '0;
        res_v[1] = '0;
        n = 2'd0;
        do_hdr = 1'b0;
        hdr_hash = eob;
        do_seq = 1'b0;

        if (first_reg)
        begin
            first_next = 1'b0;
            id_next = base_id;
            if (b != CHAR_GT)
            begin
                err_next = 1'b1;
                res_v[0].format_error = 1'b1;
                n = 2'd1;
            end
            else
            begin
                do_hdr = 1'b1;
            end
        end
        else if (err_reg)
        begin
            n = 2'd0;
        end
        else if (pend_reg)
        begin
            pend_next = 1'b0;
            if (b == CHAR_GT)
            begin
                res_v[0] = record_item(pos_next, hash_next, hstart_next, id_next, delim,
                                       max_next, sum_next);
                max_next = res_v[0].longest_residue;
                sum_next = res_v[0].total_residue;
                id_next = id_next + 32'd1;
                pos_next = idx_t'(pos_next + idx_t'(1));
                n = 2'd1;
                do_hdr = 1'b1;
                hdr_hash = 1'b0;
            end
            else
            begin
                do_seq = 1'b1;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_HEADER:
                begin
                    if (b == CHAR_NL)
                    begin
                        hash_next = pos_next;
                        res_v[0] = byte_item(CHAR_HASH, pos_next);
                        pos_next = idx_t'(pos_next + idx_t'(1));
                        n = 2'd1;
                        mode_next = MODE_START;
                    end
                    else
                    begin
                        res_v[0] = byte_item(b, pos_next);
                        pos_next = idx_t'(pos_next + idx_t'(1));
                        n = 2'd1;
                        if (eob)
                        begin
                            hash_next = pos_next;
                            res_v[1] = byte_item(CHAR_HASH, pos_next);
                            pos_next = idx_t'(pos_next + idx_t'(1));
                            n = 2'd2;
                        end
                    end
                end
                MODE_SEQ:
                begin
                    do_seq = 1'b1;
                end
                default:
                begin
                    if (b == CHAR_GT)
                    begin
                        do_hdr = 1'b1;
                    end
                    else
                    begin
                        do_seq = 1'b1;
                    end
                end
            endcase
        end

        if (do_hdr)
        begin
            hstart_next = pos_next;
            mode_next = MODE_HEADER;
            res_v[n[0]] = byte_item(b, pos_next);
            pos_next = idx_t'(pos_next + idx_t'(1));
            n = n + 2'd1;
            if (hdr_hash)
            begin
                hash_next = pos_next;
                res_v[n[0]] = byte_item(CHAR_HASH, pos_next);
                pos_next = idx_t'(pos_next + idx_t'(1));
                n = n + 2'd1;
            end
        end

        if (do_seq)
        begin
            mode_next = MODE_SEQ;
            if (b == CHAR_NL)
            begin
                if (eob)
                begin
                    res_v[0] = record_item(pos_next, hash_next, hstart_next, id_next, delim,
                                           max_next, sum_next);
                    max_next = res_v[0].longest_residue;
                    sum_next = res_v[0].total_residue;
                    id_next = id_next + 32'd1;
                    pos_next = idx_t'(pos_next + idx_t'(1));
                    n = 2'd1;
                end
                else
                begin
                    pend_next = 1'b1;
                end
            end
            else
            begin
                res_v[0] = byte_item(b, pos_next);
                pos_next = idx_t'(pos_next + idx_t'(1));
                n = 2'd1;
                if (eob)
                begin
                    res_v[1] = record_item(pos_next, hash_next, hstart_next, id_next, delim,
                                           max_next, sum_next);
                    max_next = res_v[1].longest_residue;
                    sum_next = res_v[1].total_residue;
                    id_next = id_next + 32'd1;
                    pos_next = idx_t'(pos_next + idx_t'(1));
                    n = 2'd2;
                end
            end
        end

        if (n == 2'd2)
        begin
            res_v[1].run_last = 1'b1;
        end
        else if (n == 2'd1)
        begin
            res_v[0].run_last = 1'b1;
        end

        // buffer restart; running max and sum survive
        if (eob)
        begin
            mode_next = MODE_START;
            pend_next = 1'b0;
            first_next = 1'b1;
            err_next = 1'b0;
            pos_next = '0;
            hstart_next = '0;
            hash_next = '0;
            id_next = base_id;
        end
    end

    assign push.count = go ? n : 2'd0;
    assign push.item[0] = res_v[0];
    assign push.item[1] = res_v[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_START;
            pend_reg <= 1'b0;
            first_reg <= 1'b1;
            err_reg <= 1'b0;
            pos_reg <= '0;
            hstart_reg <= '0;
            hash_reg <= '0;
            id_reg <= '0;
            max_reg <= '0;
            sum_reg <= '0;
        end
        else if (go)
        begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            first_reg <= first_next;
            err_reg <= err_next;
            pos_reg <= pos_next;
            hstart_reg <= hstart_next;
            hash_reg <= hash_next;
            id_reg <= id_next;
            max_reg <= max_next;
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/fpi_outq.sv @@
// Result queue: takes up to two results a cycle, hands out one a cycle while out_ready is high.
`default_nettype none

module fpi_outq
    import fpi_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      head
);

    result_t                mem_reg [OQ_DEPTH];
    logic [OQ_PTR_BITS-1:0] head_reg, head_next;
    logic [OQ_PTR_BITS-1:0] tail_reg, tail_next;
    logic [OQ_PTR_BITS-1:0] tail_plus1;
    logic [OQ_CNT_BITS-1:0] count_reg, count_next;
    logic                   pop;

    assign out_valid = (count_reg != '0);
    assign head = mem_reg[head_reg];
    assign room = (count_reg <= OQ_CNT_BITS'(OQ_DEPTH - 2));
    assign pop = out_valid && out_ready;
    assign tail_plus1 = OQ_PTR_BITS'(tail_reg + 1'b1);

    always_comb
    begin
        head_next = pop ? OQ_PTR_BITS'(head_reg + 1'b1) : head_reg;
        tail_next = OQ_PTR_BITS'(tail_reg + OQ_PTR_BITS'(push.count));
        count_next = OQ_CNT_BITS'(count_reg + OQ_CNT_BITS'(push.count)
                                  - OQ_CNT_BITS'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[tail_reg] <= push.item[0];
        end
        if (push.count == 2'd2)
        begin
            mem_reg[tail_plus1] <= push.item[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire
